// ===== design/mch_pkg.sv =====
`timescale 1ns / 1ps

package mch_pkg;

  localparam int DEQUE_DEPTH = 64;
  localparam int COORD_WIDTH = 16;
  localparam int PTR_W       = $clog2(DEQUE_DEPTH);
  localparam int CNT_W       = $clog2(DEQUE_DEPTH + 1);
  localparam int PT_W        = 2 * COORD_WIDTH;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;

  // The vertex counter reads 0..2 while the first vertices are buffered.
  localparam logic [1:0] VC_RUNNING = 2'd3;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] x;
  } pt_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_CMP,
    ST_SEED_WR,
    ST_RDF,
    ST_MULF,
    ST_CMPF,
    ST_FDEC,
    ST_RDB,
    ST_MULB,
    ST_CMPB,
    ST_DONE,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_SHORT
  } state_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == ptr_t'(DEQUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? ptr_t'(DEQUE_DEPTH - 1) : ptr_t'(p - 1'b1);
  endfunction

  function automatic logic signed [DIFF_W-1:0] coord_diff(input logic [COORD_WIDTH-1:0] a,
                                                          input logic [COORD_WIDTH-1:0] b);
    return $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
  endfunction

endpackage

// ===== design/melkman_convex_hull_top.sv =====
`timescale 1ns / 1ps

// Online convex hull of a simple polygon by Melkman's deque. Vertices arrive one item at a
// time; s_tuser marks the first vertex of a polygon and s_tlast the last. The first two
// vertices are buffered and the third seeds the deque. A later vertex that lies outside
// the hull pops entries at the front and at the back and is pushed at both ends: every turn
// test on the deque waits on a registered read from its memory's two read ports, a registered
// product pair and a compare. On the last vertex the hull is sent front to back one item at
// a time, each entry read from the same memory once the output register is free; the
// overflow flag on m_tuser tells that a push onto the full deque was dropped.
module melkman_convex_hull_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mch_pkg::PT_W-1:0]       s_tdata,  // point_x, point_y
  input  logic                           s_tuser,  // first_vertex
  input  logic                           s_tlast,  // last_vertex
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mch_pkg::PT_W-1:0]       m_tdata,  // hull_x, hull_y
  output logic                           m_tuser,  // overflowed
  output logic                           m_tlast   // end_of_hull
);

  mch_pkg::state_t state, state_next;
  mch_pkg::ptr_t   front_pointer, front_pointer_next;
  mch_pkg::ptr_t   back_pointer, back_pointer_next;
  mch_pkg::cnt_t   entry_count, entry_count_next;
  logic [1:0]      vertex_count, vertex_count_next;
  logic            overflow_flag, overflow_flag_next;
  logic            init, init_next;

  mch_pkg::pt_t    seed0, seed0_next;
  mch_pkg::pt_t    seed1, seed1_next;
  mch_pkg::pt_t    pt_cur, pt_cur_next;
  logic            last_flag, last_flag_next;
  logic            fturn, fturn_next;
  logic            seedturn, seedturn_next;
  logic [1:0]      seed_k, seed_k_next;
  mch_pkg::ptr_t   out_idx, out_idx_next;
  mch_pkg::cnt_t   out_left, out_left_next;
  logic            sh_idx, sh_idx_next;
  logic            sh_last, sh_last_next;

  logic signed [mch_pkg::PROD_W-1:0] prod1, prod2, prod1_next, prod2_next;
  mch_pkg::pt_t    op_a, op_b, op_c;
  logic            right;

  mch_pkg::pt_t    mem [mch_pkg::DEQUE_DEPTH];
  logic            mem_we;
  mch_pkg::ptr_t   mem_waddr, raddr_a, raddr_b;
  mch_pkg::pt_t    mem_wdata, rd_a, rd_b;

  logic            do_pushf, do_pushb;
  mch_pkg::pt_t    push_pt;
  logic            load_out, load_last;
  mch_pkg::pt_t    load_pt;
  logic            out_free;
  mch_pkg::cnt_t   hull_cnt;

  assign s_tready = (state == mch_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign hull_cnt = (entry_count > mch_pkg::cnt_t'(1)) ? mch_pkg::cnt_t'(entry_count - 1'b1)
                                                      : entry_count;

  // Deque storage: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  // Turn test right(a,b,c): products are registered, the compare works on the registered products.
  always_comb begin
    logic signed [mch_pkg::DIFF_W-1:0] d1, d2, d3, d4;
    d1 = mch_pkg::coord_diff(op_c.x, op_b.x);
    d2 = mch_pkg::coord_diff(op_a.y, op_b.y);
    d3 = mch_pkg::coord_diff(op_a.x, op_b.x);
    d4 = mch_pkg::coord_diff(op_c.y, op_b.y);
    prod1_next = d1 * d2;
    prod2_next = d3 * d4;
  end

  assign right = (prod1 > prod2);

  always_comb begin
    logic [1:0] vc_eff;
    vc_eff              = vertex_count;
    state_next          = state;
    front_pointer_next  = front_pointer;
    back_pointer_next   = back_pointer;
    entry_count_next    = entry_count;
    vertex_count_next   = vertex_count;
    overflow_flag_next  = overflow_flag;
    init_next           = init;
    seed0_next          = seed0;
    seed1_next          = seed1;
    pt_cur_next         = pt_cur;
    last_flag_next      = last_flag;
    fturn_next          = fturn;
    seedturn_next       = seedturn;
    seed_k_next         = seed_k;
    out_idx_next        = out_idx;
    out_left_next       = out_left;
    sh_idx_next         = sh_idx;
    sh_last_next        = sh_last;
    mem_we              = 1'b0;
    mem_waddr           = front_pointer;
    mem_wdata           = pt_cur;
    raddr_a             = front_pointer;
    raddr_b             = mch_pkg::ptr_inc(front_pointer);
    op_a                = rd_b;
    op_b                = rd_a;
    op_c                = pt_cur;
    do_pushf            = 1'b0;
    do_pushb            = 1'b0;
    push_pt             = pt_cur;
    load_out            = 1'b0;
    load_pt             = rd_a;
    load_last           = 1'b0;

    unique case (state)
      mch_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          pt_cur_next    = s_tdata;
          last_flag_next = s_tlast;
          if (s_tuser) begin
            vc_eff             = 2'd0;
            front_pointer_next = '0;
            back_pointer_next  = '0;
            entry_count_next   = '0;
          end
          case (vc_eff)
            2'd0: begin
              overflow_flag_next = 1'b0;
              front_pointer_next = '0;
              back_pointer_next  = '0;
              entry_count_next   = '0;
              seed0_next         = s_tdata;
              vertex_count_next  = 2'd1;
              if (s_tlast) begin
                vertex_count_next = 2'd0;
                sh_idx_next       = 1'b0;
                sh_last_next      = 1'b0;
                state_next        = mch_pkg::ST_SHORT;
              end
            end
            2'd1: begin
              seed1_next        = s_tdata;
              vertex_count_next = 2'd2;
              if (s_tlast) begin
                vertex_count_next  = 2'd0;
                front_pointer_next = '0;
                back_pointer_next  = '0;
                entry_count_next   = '0;
                sh_idx_next        = 1'b0;
                sh_last_next       = 1'b1;
                state_next         = mch_pkg::ST_SHORT;
              end
            end
            2'd2: begin
              front_pointer_next = '0;
              back_pointer_next  = '0;
              entry_count_next   = '0;
              vertex_count_next  = mch_pkg::VC_RUNNING;
              state_next         = mch_pkg::ST_SEED_MUL;
            end
            default: begin
              init_next  = 1'b1;
              state_next = mch_pkg::ST_RDF;
            end
          endcase
        end
      end
      mch_pkg::ST_SEED_MUL: begin
        op_a       = seed0;
        op_b       = seed1;
        state_next = mch_pkg::ST_SEED_CMP;
      end
      mch_pkg::ST_SEED_CMP: begin
        seedturn_next = right;
        seed_k_next   = 2'd0;
        state_next    = mch_pkg::ST_SEED_WR;
      end
      mch_pkg::ST_SEED_WR: begin
        // Pushed at the front in turn: the vertex, two seeds ordered by the turn, the vertex.
        do_pushf = 1'b1;
        case (seed_k)
          2'd1:    push_pt = seedturn ? seed0 : seed1;
          2'd2:    push_pt = seedturn ? seed1 : seed0;
          default: push_pt = pt_cur;
        endcase
        seed_k_next = seed_k + 2'd1;
        if (seed_k == 2'd3) begin
          state_next = mch_pkg::ST_DONE;
        end
      end
      mch_pkg::ST_RDF: begin
        raddr_a    = front_pointer;
        raddr_b    = mch_pkg::ptr_inc(front_pointer);
        state_next = mch_pkg::ST_MULF;
      end
      mch_pkg::ST_MULF: begin
        op_a       = rd_b;
        op_b       = rd_a;
        state_next = mch_pkg::ST_CMPF;
      end
      mch_pkg::ST_CMPF: begin
        fturn_next = right;
        state_next = init ? mch_pkg::ST_RDB : mch_pkg::ST_FDEC;
      end
      mch_pkg::ST_FDEC: begin
        if (entry_count > mch_pkg::cnt_t'(2) && !fturn) begin
          front_pointer_next = mch_pkg::ptr_inc(front_pointer);
          entry_count_next   = entry_count - 1'b1;
          state_next         = mch_pkg::ST_RDF;
        end else begin
          do_pushf   = 1'b1;
          state_next = mch_pkg::ST_RDB;
        end
      end
      mch_pkg::ST_RDB: begin
        raddr_a    = back_pointer;
        raddr_b    = mch_pkg::ptr_dec(back_pointer);
        state_next = mch_pkg::ST_MULB;
      end
      mch_pkg::ST_MULB: begin
        op_a       = rd_a;
        op_b       = rd_b;
        state_next = mch_pkg::ST_CMPB;
      end
      mch_pkg::ST_CMPB: begin
        if (init) begin
          // A vertex inside both end wedges leaves the hull unchanged.
          init_next  = 1'b0;
          state_next = (fturn && right) ? mch_pkg::ST_DONE : mch_pkg::ST_FDEC;
        end else if (entry_count > mch_pkg::cnt_t'(2) && !right) begin
          back_pointer_next = mch_pkg::ptr_dec(back_pointer);
          entry_count_next  = entry_count - 1'b1;
          state_next        = mch_pkg::ST_RDB;
        end else begin
          do_pushb   = 1'b1;
          state_next = mch_pkg::ST_DONE;
        end
      end
      mch_pkg::ST_DONE: begin
        if (!last_flag) begin
          state_next = mch_pkg::ST_IDLE;
        end else if (hull_cnt == '0) begin
          front_pointer_next = '0;
          back_pointer_next  = '0;
          entry_count_next   = '0;
          vertex_count_next  = 2'd0;
          state_next         = mch_pkg::ST_IDLE;
        end else begin
          out_idx_next  = front_pointer;
          out_left_next = hull_cnt;
          state_next    = mch_pkg::ST_OUT_RD;
        end
      end
      mch_pkg::ST_OUT_RD: begin
        // The state moves on to the load only when the output register is free next cycle.
        raddr_a = out_idx;
        if (out_free) begin
          state_next = mch_pkg::ST_OUT_LD;
        end
      end
      mch_pkg::ST_OUT_LD: begin
        load_out      = 1'b1;
        load_pt       = rd_a;
        load_last     = (out_left == mch_pkg::cnt_t'(1));
        out_idx_next  = mch_pkg::ptr_inc(out_idx);
        out_left_next = out_left - 1'b1;
        if (out_left == mch_pkg::cnt_t'(1)) begin
          front_pointer_next = '0;
          back_pointer_next  = '0;
          entry_count_next   = '0;
          vertex_count_next  = 2'd0;
          state_next         = mch_pkg::ST_IDLE;
        end else begin
          state_next = mch_pkg::ST_OUT_RD;
        end
      end
      mch_pkg::ST_SHORT: begin
        if (out_free) begin
          load_out    = 1'b1;
          load_pt     = sh_idx ? seed1 : seed0;
          load_last   = (sh_idx == sh_last);
          sh_idx_next = 1'b1;
          if (sh_idx == sh_last) begin
            state_next = mch_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = mch_pkg::ST_IDLE;
      end
    endcase

    // A push onto a full deque is dropped and only sets the sticky flag.
    if (do_pushf) begin
      if (entry_count >= mch_pkg::cnt_t'(mch_pkg::DEQUE_DEPTH)) begin
        overflow_flag_next = 1'b1;
      end else begin
        mem_we           = 1'b1;
        mem_wdata        = push_pt;
        entry_count_next = entry_count + 1'b1;
        if (entry_count == '0) begin
          back_pointer_next = front_pointer;
          mem_waddr         = front_pointer;
        end else begin
          front_pointer_next = mch_pkg::ptr_dec(front_pointer);
          mem_waddr          = mch_pkg::ptr_dec(front_pointer);
        end
      end
    end
    if (do_pushb) begin
      if (entry_count >= mch_pkg::cnt_t'(mch_pkg::DEQUE_DEPTH)) begin
        overflow_flag_next = 1'b1;
      end else begin
        mem_we           = 1'b1;
        mem_wdata        = push_pt;
        entry_count_next = entry_count + 1'b1;
        if (entry_count == '0) begin
          front_pointer_next = back_pointer;
          mem_waddr          = back_pointer;
        end else begin
          back_pointer_next = mch_pkg::ptr_inc(back_pointer);
          mem_waddr         = mch_pkg::ptr_inc(back_pointer);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mch_pkg::ST_IDLE;
      front_pointer <= '0;
      back_pointer  <= '0;
      entry_count   <= '0;
      vertex_count  <= 2'd0;
      overflow_flag <= 1'b0;
      init          <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state         <= state_next;
      front_pointer <= front_pointer_next;
      back_pointer  <= back_pointer_next;
      entry_count   <= entry_count_next;
      vertex_count  <= vertex_count_next;
      overflow_flag <= overflow_flag_next;
      init          <= init_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    seed0     <= seed0_next;
    seed1     <= seed1_next;
    pt_cur    <= pt_cur_next;
    last_flag <= last_flag_next;
    fturn     <= fturn_next;
    seedturn  <= seedturn_next;
    seed_k    <= seed_k_next;
    out_idx   <= out_idx_next;
    out_left  <= out_left_next;
    sh_idx    <= sh_idx_next;
    sh_last   <= sh_last_next;
    prod1     <= prod1_next;
    prod2     <= prod2_next;
    if (load_out) begin
      m_tdata <= load_pt;
      m_tlast <= load_last;
      m_tuser <= overflow_flag;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= mch_pkg::cnt_t'(mch_pkg::DEQUE_DEPTH))
    else $error("deque entry count beyond its depth");

  a_running_min: assert property (@(posedge clk) disable iff (rst)
    (state == mch_pkg::ST_IDLE && vertex_count == mch_pkg::VC_RUNNING)
      |-> entry_count >= mch_pkg::cnt_t'(2))
    else $error("running deque holds fewer than two entries");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!m_tvalid || m_tready))
    else $error("output item overwritten before it was taken");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == mch_pkg::ST_OUT_LD && out_left == mch_pkg::cnt_t'(1))
      |=> (state == mch_pkg::ST_IDLE && vertex_count == 2'd0 && entry_count == '0))
    else $error("deque not emptied after the last hull item");
`endif

endmodule
